// ===== design/indexed_list_manager_macros.svh =====
// Assertion macros for the indexed list manager
`ifndef INDEXED_LIST_MANAGER_MACROS_SVH
`define INDEXED_LIST_MANAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ILM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilm assertion failed");

// next-cycle implication, checked outside reset
`define ILM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilm assertion failed");

`endif

// ===== design/ilm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ilm_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FPOS_W    = 6;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [REQ_W-1:0] OP_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] OP_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] OP_EDIT   = 3'd3;
  localparam logic [REQ_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] UPD_NONE = 2'd0;
  localparam logic [1:0] UPD_INS  = 2'd1;
  localparam logic [1:0] UPD_DEL  = 2'd2;
  localparam logic [1:0] UPD_WR   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [1:0] upd;
  } ilm_cmd_t;

endpackage

`default_nettype wire

// ===== design/ilm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilm_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                           clk,
  input  wire ilm_pkg::ilm_cmd_t              cmd,
  input  wire logic [IDX_W-1:0]               cmd_pos,
  input  wire logic [ilm_pkg::VAL_W-1:0]      cmd_val,
  input  wire logic [ilm_pkg::VAL_W-1:0]      left_entry,
  input  wire logic [ilm_pkg::VAL_W-1:0]      right_entry,
  input  wire logic [ilm_pkg::VAL_W-1:0]      right_rd,
  output logic      [ilm_pkg::VAL_W-1:0]      entry,
  output logic      [ilm_pkg::VAL_W-1:0]      rd
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ilm_pkg::VAL_W-1:0] entry_r;
  logic [ilm_pkg::VAL_W-1:0] entry_nxt;
  logic [ilm_pkg::VAL_W-1:0] rd_r;
  logic [ilm_pkg::VAL_W-1:0] rd_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.upd)
      ilm_pkg::UPD_INS: begin
        if (MY_IDX > cmd_pos) begin
          entry_nxt = left_entry;
        end else if (MY_IDX == cmd_pos) begin
          entry_nxt = cmd_val;
        end
      end
      ilm_pkg::UPD_DEL: begin
        if (MY_IDX >= cmd_pos) begin
          entry_nxt = right_entry;
        end
      end
      ilm_pkg::UPD_WR: begin
        if (MY_IDX == cmd_pos) begin
          entry_nxt = cmd_val;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      rd_nxt = entry_r;
    end else if (cmd.shift) begin
      rd_nxt = right_rd;
    end else begin
      rd_nxt = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry = entry_r;
  assign rd    = rd_r;

endmodule

`default_nettype wire

// ===== design/indexed_list_manager.sv =====
// Insert, clear, unused codes, range errors and an empty-list search go from idle straight to finish.
// Delete and edit walk to the position first, and search walks until a match or the last entry.
// The walk moves the read chain one cell per cycle toward cell 0, so time grows with position.
// Busy drops with the strobe, so a new request can go in with the strobe but not before it.
// Reset (rst_n low, synchronous) empties the list and idles the controller; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_manager_macros.svh"

module indexed_list_manager #(
  parameter int unsigned DEPTH = ilm_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [ilm_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic        [ilm_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [ilm_pkg::VAL_W-1:0]    in_value_in,
  output logic                                     out_valid,
  output logic                                     out_status,
  output logic signed      [ilm_pkg::VAL_W-1:0]    out_value_out,
  output logic             [ilm_pkg::FPOS_W-1:0]   out_found_position,
  output logic             [ilm_pkg::CNT_OUT_W-1:0] out_count_after
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > ilm_pkg::POS_W) ? CNT_W : ilm_pkg::POS_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [ilm_pkg::REQ_W-1:0]      op_r, op_nxt;
  logic [ilm_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [ilm_pkg::VAL_W-1:0]      val_r, val_nxt;
  logic [IDX_W-1:0]               k_r, k_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           ok_r, ok_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_status_r, out_status_nxt;
  logic [ilm_pkg::VAL_W-1:0]      out_value_r, out_value_nxt;
  logic [ilm_pkg::FPOS_W-1:0]     out_found_r, out_found_nxt;
  logic [ilm_pkg::CNT_OUT_W-1:0]  out_count_r, out_count_nxt;

  ilm_pkg::ilm_cmd_t              cmd;
  logic [ilm_pkg::VAL_W-1:0]      entry_w [DEPTH];
  logic [ilm_pkg::VAL_W-1:0]      rd_w    [DEPTH];
  logic [CMP_W-1:0]               in_pos_ext;
  logic [CMP_W-1:0]               cnt_ext;
  logic                           accept;

  assign in_pos_ext = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_r);
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    ok_nxt         = ok_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    cmd.load       = 1'b0;
    cmd.shift      = 1'b0;
    cmd.upd        = ilm_pkg::UPD_NONE;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt         = in_req_type;
          pos_nxt        = in_position;
          val_nxt        = in_value_in;
          k_nxt          = '0;
          cmd.load       = 1'b1;
          ok_nxt         = 1'b0;
          out_status_nxt = 1'b1;
          out_value_nxt  = '0;
          out_found_nxt  = '0;
          state_nxt      = ST_FINISH;
          unique case (in_req_type) inside
            ilm_pkg::OP_INSERT: begin
              ok_nxt         = (count_r < CNT_W'(DEPTH)) && (in_pos_ext <= cnt_ext);
              out_status_nxt = !ok_nxt;
            end
            ilm_pkg::OP_DELETE, ilm_pkg::OP_EDIT: begin
              if (in_pos_ext < cnt_ext) begin
                state_nxt = ST_WALK;
              end
            end
            ilm_pkg::OP_SEARCH: begin
              if (count_r != '0) begin
                state_nxt = ST_WALK;
              end
            end
            ilm_pkg::OP_CLEAR: begin
              ok_nxt         = 1'b1;
              out_status_nxt = 1'b0;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (op_r == ilm_pkg::OP_SEARCH) begin
          if (rd_w[0] == val_r) begin
            out_status_nxt = 1'b0;
            out_found_nxt  = ilm_pkg::FPOS_W'(k_r);
            state_nxt      = ST_FINISH;
          end else if ((CNT_W'(k_r) + CNT_W'(1)) == count_r) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.shift = 1'b1;
            k_nxt     = k_r + IDX_W'(1);
          end
        end else begin
          if (CMP_W'(k_r) == CMP_W'(pos_r)) begin
            ok_nxt         = 1'b1;
            out_status_nxt = 1'b0;
            out_value_nxt  = rd_w[0];
            state_nxt      = ST_FINISH;
          end else begin
            cmd.shift = 1'b1;
            k_nxt     = k_r + IDX_W'(1);
          end
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (ok_r) begin
          unique case (op_r)
            ilm_pkg::OP_INSERT: begin
              cmd.upd   = ilm_pkg::UPD_INS;
              count_nxt = count_r + CNT_W'(1);
            end
            ilm_pkg::OP_DELETE: begin
              cmd.upd   = ilm_pkg::UPD_DEL;
              count_nxt = count_r - CNT_W'(1);
            end
            ilm_pkg::OP_EDIT: begin
              cmd.upd = ilm_pkg::UPD_WR;
            end
            ilm_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              cmd.upd = ilm_pkg::UPD_NONE;
            end
          endcase
        end
        out_count_nxt = ilm_pkg::CNT_OUT_W'(count_nxt);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    k_r          <= k_nxt;
    ok_r         <= ok_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ilm_pkg::VAL_W-1:0] left_w;
    logic [ilm_pkg::VAL_W-1:0] right_w;
    logic [ilm_pkg::VAL_W-1:0] right_rd_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w    = entry_w[i];
      assign right_rd_w = '0;
    end else begin : g_inner
      assign right_w    = entry_w[i+1];
      assign right_rd_w = rd_w[i+1];
    end

    ilm_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cmd_pos     (IDX_W'(pos_r)),
      .cmd_val     (val_r),
      .left_entry  (left_w),
      .right_entry (right_w),
      .right_rd    (right_rd_w),
      .entry       (entry_w[i]),
      .rd          (rd_w[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_value_out      = out_value_r;
  assign out_found_position = out_found_r;
  assign out_count_after    = out_count_r;

  `ILM_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `ILM_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ILM_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  `ILM_ASSERT_NXT(a_finish_strobe, clk, rst_n, state_r == ST_FINISH, out_valid_r)
  `ILM_ASSERT_IMP(a_walk_bound, clk, rst_n, state_r == ST_WALK, CNT_W'(k_r) < count_r)

endmodule

`default_nettype wire
